### hdl/bmp_stream_to_argb_core_macros.svh
`ifndef BMP_STREAM_TO_ARGB_CORE_MACROS_SVH
`define BMP_STREAM_TO_ARGB_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define BSA_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define BSA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/bsa_pkg.sv
`default_nettype none

package bsa_pkg;

	localparam int MAX_DIM_DEF = 2048;
	localparam int COORD_W     = 11;

	typedef enum logic [1:0] {
		ST_PIXEL  = 2'd0,
		ST_REJECT = 2'd1,
		ST_TRUNC  = 2'd2,
		ST_DONE   = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       file_start;
		logic       file_end;
	} item_t;

	typedef struct packed {
		status_t              status;
		logic [COORD_W-1:0]   pixel_x;
		logic [COORD_W-1:0]   pixel_y;
		logic [31:0]          argb_pixel;
		logic                 final_res;
	} result_t;

	// up to two results caused by one item, first one in r0
	typedef struct packed {
		logic    r0_v;
		result_t r0;
		logic    r1_v;
		result_t r1;
	} pair_t;

endpackage

`default_nettype wire

### hdl/bsa_parser.sv
`default_nettype none

module bsa_parser import bsa_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  advance,
	input  wire item_t item,
	output pair_t      results
);

	localparam int DIM_W        = $clog2(MAX_DIM + 1);
	localparam int STRIDE_W     = $clog2(4 * MAX_DIM + 1);
	localparam int HEADER_BYTES = 54;
	localparam logic [5:0] HDR_LAST = 6'(HEADER_BYTES - 1);
	localparam logic [5:0] POS_OFS  = 6'd10;
	localparam logic [5:0] POS_WID  = 6'd18;
	localparam logic [5:0] POS_HGT  = 6'd22;
	localparam logic [5:0] POS_DEP  = 6'd28;
	localparam logic [5:0] POS_CMP  = 6'd30;
	localparam logic [7:0] MAGIC_B  = 8'h42;
	localparam logic [7:0] MAGIC_M  = 8'h4D;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_HEAD = 3'd1,
		PH_SKIP = 3'd2,
		PH_PIX  = 3'd3,
		PH_DONE = 3'd4
	} phase_t;

	phase_t               phase_q, phase_d, eff_phase;
	logic [31:0]          pos_q, pos_d, eff_pos, pos_inc, pos_sat;
	logic [31:0]          offset_q, offset_d, width_q, width_d, height_q, height_d;
	logic [31:0]          comp_q, comp_d, h_mag;
	logic [15:0]          depth_q, depth_d;
	logic                 magic_q, magic_d;
	logic [DIM_W-1:0]     img_w_q, img_w_d, img_h_q, img_h_d;
	logic [DIM_W-1:0]     rows_q, rows_d, col_q, col_d, rows_inc, row_y;
	logic                 no_flip_q, no_flip_d, pb4_q, pb4_d;
	logic [STRIDE_W-1:0]  stride_q, stride_d, rbi_q, rbi_d, rbi_inc;
	logic [STRIDE_W:0]    row_raw, stride_raw;
	logic [1:0]           sub_q, sub_d;
	logic [23:0]          part_q, part_d;
	logic [5:0]           hp, hp_ofs, hp_wid, hp_hgt, hp_dep, hp_cmp;
	logic                 h_neg, hdr_ok, active, pix_v, stat_v;
	status_t              stat_code;
	result_t              pix_res, stat_res;

	assign eff_phase = item.file_start ? PH_HEAD : phase_q;
	assign eff_pos   = item.file_start ? 32'd0 : pos_q;
	assign pos_inc   = eff_pos + 32'd1;
	assign pos_sat   = (&eff_pos) ? eff_pos : pos_inc;

	assign hp     = eff_pos[5:0];
	assign hp_ofs = hp - POS_OFS;
	assign hp_wid = hp - POS_WID;
	assign hp_hgt = hp - POS_HGT;
	assign hp_dep = hp - POS_DEP;
	assign hp_cmp = hp - POS_CMP;

	// header checks on the gathered words
	assign h_neg  = height_q[31];
	assign h_mag  = h_neg ? (32'd0 - height_q) : height_q;
	assign hdr_ok = magic_q
		&& (width_q != 32'd0) && (width_q <= 32'(MAX_DIM))
		&& (h_mag != 32'd0) && (h_mag <= 32'(MAX_DIM))
		&& ((depth_q == 16'd24) || (depth_q == 16'd32))
		&& (comp_q == 32'd0)
		&& (offset_q >= 32'(HEADER_BYTES));

	// row stride rounded up to four bytes
	always_comb begin
		if (depth_q == 16'd32) begin
			row_raw = (STRIDE_W+1)'({width_q[DIM_W-1:0], 2'b00});
		end else begin
			row_raw = (STRIDE_W+1)'({width_q[DIM_W-1:0], 1'b0})
				+ (STRIDE_W+1)'(width_q[DIM_W-1:0]);
		end
		stride_raw = (row_raw + (STRIDE_W+1)'(3)) & ~(STRIDE_W+1)'(3);
	end

	assign rbi_inc  = rbi_q + STRIDE_W'(1);
	assign rows_inc = rows_q + DIM_W'(1);
	assign row_y    = no_flip_q ? rows_q : (img_h_q - DIM_W'(1) - rows_q);

	always_comb begin
		phase_d    = phase_q;
		pos_d      = pos_q;
		offset_d   = offset_q;
		width_d    = width_q;
		height_d   = height_q;
		depth_d    = depth_q;
		comp_d     = comp_q;
		magic_d    = magic_q;
		img_w_d    = img_w_q;
		img_h_d    = img_h_q;
		no_flip_d  = no_flip_q;
		pb4_d      = pb4_q;
		stride_d   = stride_q;
		rbi_d      = rbi_q;
		rows_d     = rows_q;
		col_d      = col_q;
		sub_d      = sub_q;
		part_d     = part_q;
		active     = 1'b0;
		pix_v      = 1'b0;
		stat_v     = 1'b0;
		stat_code  = ST_DONE;
		pix_res    = '0;

		unique case (eff_phase)
			PH_HEAD: begin
				active  = 1'b1;
				phase_d = PH_HEAD;
				pos_d   = pos_inc;
				if (hp == 6'd0) begin
					magic_d = (item.data_byte == MAGIC_B);
				end else if (hp == 6'd1) begin
					magic_d = magic_q & (item.data_byte == MAGIC_M);
				end else if (hp_ofs < 6'd4) begin
					offset_d[{hp_ofs[1:0], 3'b000} +: 8] = item.data_byte;
				end else if (hp_wid < 6'd4) begin
					width_d[{hp_wid[1:0], 3'b000} +: 8] = item.data_byte;
				end else if (hp_hgt < 6'd4) begin
					height_d[{hp_hgt[1:0], 3'b000} +: 8] = item.data_byte;
				end else if (hp_dep < 6'd2) begin
					depth_d[{hp_dep[0], 3'b000} +: 8] = item.data_byte;
				end else if (hp_cmp < 6'd4) begin
					comp_d[{hp_cmp[1:0], 3'b000} +: 8] = item.data_byte;
				end
				if (hp == HDR_LAST) begin
					if (!hdr_ok) begin
						stat_v    = 1'b1;
						stat_code = ST_REJECT;
						phase_d   = PH_DONE;
					end else begin
						img_w_d    = width_q[DIM_W-1:0];
						img_h_d    = h_mag[DIM_W-1:0];
						no_flip_d  = h_neg;
						pb4_d      = (depth_q == 16'd32);
						stride_d   = stride_raw[STRIDE_W-1:0];
						rbi_d      = '0;
						rows_d     = '0;
						col_d      = '0;
						sub_d      = '0;
						part_d     = '0;
						phase_d    = (pos_inc >= offset_q) ? PH_PIX : PH_SKIP;
					end
				end
			end
			PH_SKIP: begin
				active  = 1'b1;
				pos_d   = pos_sat;
				phase_d = (pos_sat >= offset_q) ? PH_PIX : PH_SKIP;
			end
			PH_PIX: begin
				active = 1'b1;
				pos_d  = pos_sat;
				if (col_q < img_w_q) begin
					if (sub_q != 2'd3) begin
						part_d[{sub_q, 3'b000} +: 8] = item.data_byte;
					end
					if (sub_q == (pb4_q ? 2'd3 : 2'd2)) begin
						pix_v              = 1'b1;
						pix_res.status     = ST_PIXEL;
						pix_res.pixel_x    = COORD_W'(col_q);
						pix_res.pixel_y    = COORD_W'(row_y);
						pix_res.argb_pixel = {8'hFF, part_d};
						pix_res.final_res  = 1'b0;
						col_d              = col_q + DIM_W'(1);
						sub_d              = '0;
						part_d             = '0;
					end else begin
						sub_d = sub_q + 2'd1;
					end
				end
				if (rbi_inc >= stride_q) begin
					rbi_d  = '0;
					col_d  = '0;
					sub_d  = '0;
					part_d = '0;
					rows_d = rows_inc;
					if (rows_inc >= img_h_q) begin
						stat_v    = 1'b1;
						stat_code = ST_DONE;
						phase_d   = PH_DONE;
					end
				end else begin
					rbi_d = rbi_inc;
				end
			end
			PH_IDLE, PH_DONE: begin
				phase_d = eff_phase;
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase

		// end of file before the image is complete
		if (active && item.file_end && (phase_d != PH_DONE)) begin
			stat_v    = 1'b1;
			stat_code = ST_TRUNC;
			phase_d   = PH_DONE;
		end
	end

	always_comb begin
		stat_res           = '0;
		stat_res.status    = stat_code;
		stat_res.final_res = 1'b1;
		results.r0_v       = pix_v | stat_v;
		results.r0         = pix_v ? pix_res : stat_res;
		results.r1_v       = pix_v & stat_v;
		results.r1         = stat_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			pos_q      <= '0;
			offset_q   <= '0;
			width_q    <= '0;
			height_q   <= '0;
			depth_q    <= '0;
			comp_q     <= '0;
			magic_q    <= 1'b0;
			img_w_q    <= '0;
			img_h_q    <= '0;
			no_flip_q  <= 1'b0;
			pb4_q      <= 1'b0;
			stride_q   <= '0;
			rbi_q      <= '0;
			rows_q     <= '0;
			col_q      <= '0;
			sub_q      <= '0;
			part_q     <= '0;
		end else if (advance) begin
			phase_q    <= phase_d;
			pos_q      <= pos_d;
			offset_q   <= offset_d;
			width_q    <= width_d;
			height_q   <= height_d;
			depth_q    <= depth_d;
			comp_q     <= comp_d;
			magic_q    <= magic_d;
			img_w_q    <= img_w_d;
			img_h_q    <= img_h_d;
			no_flip_q  <= no_flip_d;
			pb4_q      <= pb4_d;
			stride_q   <= stride_d;
			rbi_q      <= rbi_d;
			rows_q     <= rows_d;
			col_q      <= col_d;
			sub_q      <= sub_d;
			part_q     <= part_d;
		end
	end

endmodule

`default_nettype wire

### hdl/bsa_result_buf.sv
`default_nettype none

module bsa_result_buf import bsa_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  load,
	input  wire pair_t results,
	input  wire logic  result_stall,
	output logic       result_valid,
	output result_t    result,
	output logic       free
);

	result_t hd_q, tl_q;
	logic    hd_v_q, tl_v_q, take;

	assign take         = hd_v_q && !result_stall;
	assign free         = !hd_v_q || (take && !tl_v_q);
	assign result_valid = hd_v_q;
	assign result       = hd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hd_v_q <= 1'b0;
			tl_v_q <= 1'b0;
		end else if (load) begin
			hd_q   <= results.r0;
			hd_v_q <= 1'b1;
			tl_q   <= results.r1;
			tl_v_q <= results.r1_v;
		end else if (take) begin
			// second result moves up once the first is taken
			if (tl_v_q) begin
				hd_q   <= tl_q;
				tl_v_q <= 1'b0;
			end else begin
				hd_v_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

### hdl/bmp_stream_to_argb_core.sv
// a result passes through the input register and then the result buffer before it is offered
// throughput: one byte per cycle while the result buffer has room for the byte's results
// the rate is set by the two-slot result register draining one result per unstalled cycle
// reset: asynchronous, active low; the parser returns to idle and both stages empty
// bytes are ignored until an item marked file_start arrives
`default_nettype none

`include "bmp_stream_to_argb_core_macros.svh"

module bmp_stream_to_argb_core import bsa_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  item_valid,
	output logic       item_stall,
	input  wire item_t item,
	output logic       result_valid,
	input  wire logic  result_stall,
	output result_t    result
);

	item_t item_s1;
	logic  valid_s1, adv, buf_free;
	pair_t results;

	// an item with no result never waits on the output side
	assign adv        = valid_s1 && (!results.r0_v || buf_free);
	assign item_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			item_s1  <= item;
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	bsa_parser #(
		.MAX_DIM (MAX_DIM)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (adv),
		.item    (item_s1),
		.results (results)
	);

	bsa_result_buf u_result_buf (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (adv && results.r0_v),
		.results      (results),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result       (result),
		.free         (buf_free)
	);

	`BSA_ASSERT_IMPL(a_final_on_status, result_valid, (result.status == ST_PIXEL) != result.final_res, "final flag does not match status")
	`BSA_ASSERT_IMPL(a_pair_order, results.r1_v, results.r0_v && (results.r0.status == ST_PIXEL) && results.r1.final_res, "second result must follow a pixel and end the file")
	`BSA_ASSERT_NEXT(a_held_item, valid_s1 && !adv, valid_s1 && $stable(item_s1), "waiting item lost or changed")

endmodule

`default_nettype wire

### tb/bmp_stream_to_argb_core_tb.sv
`timescale 1ns / 1ps

module bmp_stream_to_argb_core_tb;

	import bsa_pkg::*;

	localparam int          HDR_LEN      = 54;
	localparam int          MAX_DIM      = MAX_DIM_DEF;
	localparam bit [7:0]    MAGIC_B      = 8'h42;
	localparam bit [7:0]    MAGIC_M      = 8'h4D;
	localparam bit [15:0]   BPP_RGB      = 16'd24;
	localparam bit [15:0]   BPP_RGBA     = 16'd32;
	localparam bit [31:0]   OPAQUE       = 32'hFF00_0000;
	localparam int          SETTLE       = 12;
	localparam int          RANDOM_BYTES = 400;
	localparam longint      RUN_LIMIT_NS = 64'd10_000_000;

	typedef enum int {PH_IDLE, PH_HEAD, PH_SKIP, PH_PIX, PH_DONE} dec_phase_t;

	class bmp_decode_predictor;
		result_t     pixels_due[$];
		int unsigned mismatches;

		dec_phase_t  phase;
		bit [31:0]   pos, wid_w, hgt_w, ofs_w, cmp_w;
		bit [15:0]   bpp_w;
		bit          magic_ok;
		bit [31:0]   row_idx, rows_done, column, partial;
		bit [31:0]   img_w, img_h, px_bytes, stride;
		bit          no_flip;

		function new();
			phase = PH_IDLE;
			mismatches = 0;
			clear_file();
		endfunction

		function void clear_file();
			pos = 0; wid_w = 0; hgt_w = 0; ofs_w = 0; cmp_w = 0; bpp_w = 0;
			magic_ok = 0; row_idx = 0; rows_done = 0; column = 0; partial = 0;
			img_w = 0; img_h = 0; px_bytes = 3; stride = 0; no_flip = 0;
		endfunction

		function void emit(status_t st, bit [31:0] x, bit [31:0] y, bit [31:0] argb, bit fin);
			result_t r;
			r.status     = st;
			r.pixel_x    = x[COORD_W-1:0];
			r.pixel_y    = y[COORD_W-1:0];
			r.argb_pixel = argb;
			r.final_res  = fin;
			pixels_due.push_back(r);
		endfunction

		// little-endian header fields, other positions are don't-care
		function void header_byte(bit [7:0] b);
			bit [31:0] wb;
			wb = {24'd0, b};
			if (pos == 0) magic_ok = (b == MAGIC_B);
			else if (pos == 1) magic_ok = magic_ok & (b == MAGIC_M);
			else if (pos >= 10 && pos <= 13) ofs_w |= wb << (8 * (pos - 10));
			else if (pos >= 18 && pos <= 21) wid_w |= wb << (8 * (pos - 18));
			else if (pos >= 22 && pos <= 25) hgt_w |= wb << (8 * (pos - 22));
			else if (pos >= 28 && pos <= 29) bpp_w |= 16'(wb << (8 * (pos - 28)));
			else if (pos >= 30 && pos <= 33) cmp_w |= wb << (8 * (pos - 30));
		endfunction

		function bit accept_header();
			bit [31:0] mag;
			mag = hgt_w[31] ? 32'd0 - hgt_w : hgt_w;
			if (!magic_ok || wid_w == 0 || wid_w > MAX_DIM) return 0;
			if (mag == 0 || mag > MAX_DIM) return 0;
			if (bpp_w != BPP_RGB && bpp_w != BPP_RGBA) return 0;
			if (cmp_w != 0 || ofs_w < HDR_LEN) return 0;
			img_w    = wid_w;
			img_h    = mag;
			no_flip  = hgt_w[31];
			px_bytes = {16'd0, bpp_w} / 8;
			stride   = (img_w * px_bytes + 3) & ~32'd3;
			return 1;
		endfunction

		function void pixel_byte(bit [7:0] b);
			bit [31:0] sub, y;
			if (column < img_w) begin
				sub = row_idx - column * px_bytes;
				if (sub < 3) partial |= {24'd0, b} << (8 * sub);
				// alpha byte falls through without touching the colour
				if (sub + 1 >= px_bytes) begin
					y = no_flip ? rows_done : img_h - 1 - rows_done;
					emit(ST_PIXEL, column, y, OPAQUE | (partial & 32'h00FF_FFFF), 1'b0);
					column++;
					partial = 0;
				end
			end
			row_idx++;
			if (row_idx >= stride) begin
				row_idx = 0;
				column  = 0;
				partial = 0;
				rows_done++;
				if (rows_done >= img_h) begin
					emit(ST_DONE, 0, 0, 0, 1'b1);
					phase = PH_DONE;
				end
			end
		endfunction

		function void take_byte(item_t it);
			if (it.file_start) begin
				clear_file();
				phase = PH_HEAD;
			end
			if (phase == PH_IDLE || phase == PH_DONE) return;
			if (phase == PH_HEAD) begin
				header_byte(it.data_byte);
				pos++;
				if (pos >= HDR_LEN) begin
					if (!accept_header()) begin
						emit(ST_REJECT, 0, 0, 0, 1'b1);
						phase = PH_DONE;
						return;
					end
					phase = PH_SKIP;
				end
			end else begin
				if (phase == PH_SKIP && pos >= ofs_w) phase = PH_PIX;
				if (pos != 32'hFFFF_FFFF) pos++;
				if (phase == PH_PIX) pixel_byte(it.data_byte);
			end
			if (phase == PH_SKIP && pos >= ofs_w) phase = PH_PIX;
			if (it.file_end && phase != PH_DONE) begin
				emit(ST_TRUNC, 0, 0, 0, 1'b1);
				phase = PH_DONE;
			end
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				mismatches++;
				$display("%0t ns: %s expected %0h, got %0h", $time, name, want, got);
			end
		endfunction

		function void check_pixel(result_t got);
			result_t want;
			if (pixels_due.size() == 0) begin
				mismatches++;
				$display("%0t ns: unexpected result, expected none, got status %0d x %0d y %0d argb %h",
					$time, got.status, got.pixel_x, got.pixel_y, got.argb_pixel);
				return;
			end
			want = pixels_due.pop_front();
			compare_field("status", 32'(want.status), 32'(got.status));
			compare_field("pixel_x", 32'(want.pixel_x), 32'(got.pixel_x));
			compare_field("pixel_y", 32'(want.pixel_y), 32'(got.pixel_y));
			compare_field("argb_pixel", want.argb_pixel, got.argb_pixel);
			compare_field("final_res", 32'(want.final_res), 32'(got.final_res));
		endfunction
	endclass

	logic    clk = 1'b0;
	logic    arst_n;
	logic    item_valid;
	logic    item_stall;
	item_t   item;
	logic    result_valid;
	logic    result_stall;
	result_t result;

	bmp_decode_predictor decoder;
	bit         calm;
	bit         drained_once;
	bit [7:0]   file_bytes[$];
	int         random_bytes;

	bmp_stream_to_argb_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	function automatic void set_le(int at, bit [31:0] v, int n);
		for (int i = 0; i < n; i++) file_bytes[at + i] = v[8 * i +: 8];
	endfunction

	function automatic void begin_file(bit [31:0] w, bit [31:0] h, bit [15:0] bpp,
		bit [31:0] comp, bit [31:0] ofs);
		file_bytes.delete();
		for (int p = 0; p < HDR_LEN; p++) file_bytes.push_back(8'($urandom));
		file_bytes[0] = MAGIC_B;
		file_bytes[1] = MAGIC_M;
		set_le(10, ofs, 4);
		set_le(18, w, 4);
		set_le(22, h, 4);
		set_le(28, {16'd0, bpp}, 2);
		set_le(30, comp, 4);
	endfunction

	function automatic void add_random(int n);
		for (int i = 0; i < n; i++) file_bytes.push_back(8'($urandom));
	endfunction

	function automatic void trim_to(int n);
		while (file_bytes.size() > n) void'(file_bytes.pop_back());
	endfunction

	// break exactly one header check
	function automatic void corrupt_header();
		bit [31:0] v;
		case ($urandom_range(0, 7))
			0: file_bytes[0] = MAGIC_B ^ (8'd1 << $urandom_range(0, 7));
			1: file_bytes[1] = MAGIC_M ^ (8'd1 << $urandom_range(0, 7));
			2: set_le(18, 32'd0, 4);
			3: file_bytes[19] = file_bytes[19] | 8'h08;
			4: begin
				v = 32'(MAX_DIM + 1) + $urandom_range(0, 32'h7FFF_0000);
				set_le(22, $urandom_range(0, 1) ? 32'd0 - v : v, 4);
			end
			5: begin
				v = $urandom_range(0, 16'hFFFF);
				if (v == BPP_RGB || v == BPP_RGBA) v++;
				set_le(28, v, 2);
			end
			6: file_bytes[30 + $urandom_range(0, 3)] = 8'($urandom_range(1, 255));
			default: set_le(10, $urandom_range(0, HDR_LEN - 1), 4);
		endcase
	endfunction

	task automatic send_item(input item_t it);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item       <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		decoder.take_byte(it);
		@(negedge clk);
	endtask

	// hold the sender until every expected result has been taken
	task automatic drain();
		item_valid <= 1'b0;
		do @(negedge clk); while (decoder.pixels_due.size() != 0);
		drained_once = 1'b1;
	endtask

	task automatic send_file(input bit with_end, input int hold);
		item_t it;
		for (int i = 0; i < file_bytes.size(); i++) begin
			if (i == hold) drain();
			it.data_byte  = file_bytes[i];
			it.file_start = (i == 0);
			it.file_end   = with_end && (i == file_bytes.size() - 1);
			send_item(it);
		end
	endtask

	// stray bytes with no file_start
	task automatic send_noise(input int n);
		item_t it;
		for (int i = 0; i < n; i++) begin
			it.data_byte  = 8'($urandom);
			it.file_start = 1'b0;
			it.file_end   = 1'($urandom_range(0, 1));
			send_item(it);
		end
	endtask

	task automatic directed_files();
		send_noise(3);
		// one-byte file: start and end on the same item
		begin_file(2, 2, BPP_RGB, 0, HDR_LEN); trim_to(1); send_file(1, -1);
		// header cut short
		begin_file(2, 2, BPP_RGB, 0, HDR_LEN); trim_to(20); send_file(1, -1);
		begin_file(2, 2, BPP_RGB, 0, HDR_LEN); file_bytes[1] = 8'h4E; send_file(0, -1);
		send_noise(2);
		begin_file(0, 1, BPP_RGB, 0, HDR_LEN); send_file(0, -1);
		begin_file(MAX_DIM + 1, 1, BPP_RGB, 0, HDR_LEN); send_file(0, -1);
		begin_file(1, 0, BPP_RGB, 0, HDR_LEN); send_file(0, -1);
		begin_file(1, 32'h8000_0000, BPP_RGB, 0, HDR_LEN); send_file(0, -1);
		begin_file(1, 1, 16'd16, 0, HDR_LEN); send_file(0, -1);
		begin_file(1, 1, BPP_RGB, 1, HDR_LEN); send_file(0, -1);
		begin_file(1, 1, BPP_RGB, 0, HDR_LEN - 1); send_file(0, -1);
		// padded rows behind a gap, end lands on completion
		begin_file(3, 2, BPP_RGB, 0, HDR_LEN + 4); add_random(4 + 24); send_file(1, 60);
		// top-down 32 bit, trailing bytes after completion
		begin_file(2, 32'hFFFF_FFFE, BPP_RGBA, 0, HDR_LEN); add_random(16 + 2); send_file(0, -1);
		// no padding: last pixel and completion from one byte
		begin_file(4, 1, BPP_RGB, 0, HDR_LEN); add_random(12); send_file(0, -1);
		// pixel and end together
		begin_file(2, 2, BPP_RGB, 0, HDR_LEN); add_random(3); send_file(1, -1);
		// offset far past the data
		begin_file(1, 1, BPP_RGB, 0, 32'hFFFF_FF00); add_random(5); send_file(1, -1);
		// abandoned mid-pixel, the next start restarts
		begin_file(2, 1, BPP_RGB, 0, HDR_LEN); add_random(4); send_file(0, -1);
		// largest image, cut after a few pixels
		begin_file(MAX_DIM, MAX_DIM, BPP_RGBA, 0, HDR_LEN);
		add_random(12);
		send_file(1, -1);
	endtask

	task automatic random_file();
		int        kind, hm, hold;
		bit [31:0] w, h, ofs, total;
		bit [15:0] bpp;
		kind  = $urandom_range(0, 99);
		calm  = ($urandom_range(0, 4) == 0);
		w     = $urandom_range(1, 5);
		hm    = $urandom_range(1, 4);
		bpp   = $urandom_range(0, 1) ? BPP_RGBA : BPP_RGB;
		ofs   = ($urandom_range(0, 3) == 0) ? HDR_LEN + $urandom_range(1, 12) : HDR_LEN;
		h     = $urandom_range(0, 1) ? 32'(-hm) : 32'(hm);
		total = ofs + ((w * (bpp / 8) + 3) & ~32'd3) * hm;
		hold  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, total - 1) : -1;
		begin_file(w, h, bpp, 0, ofs);
		if (kind < 55) begin
			add_random(total - HDR_LEN);
			case ($urandom_range(0, 2))
				0: send_file(1, hold);
				1: send_file(0, hold);
				default: begin
					add_random($urandom_range(1, 4));
					send_file(1, hold);
				end
			endcase
		end else if (kind < 72) begin
			add_random(total - HDR_LEN);
			trim_to($urandom_range(1, total - 1));
			send_file(1, hold);
		end else if (kind < 85) begin
			corrupt_header();
			add_random($urandom_range(0, 6));
			send_file(1'($urandom_range(0, 1)), hold);
		end else begin
			add_random(total - HDR_LEN);
			trim_to($urandom_range(1, total - 1));
			send_file(0, hold);
		end
		random_bytes += file_bytes.size();
		if ($urandom_range(0, 4) == 0) send_noise($urandom_range(1, 5));
	endtask

	// receiver: stall runs of random length between short open windows
	initial begin
		int n;
		result_stall = 1'b0;
		@(negedge clk);
		forever begin
			n = pick_gap();
			if (n > 0) begin
				result_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			result_stall <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) decoder.check_pixel(result);
	end

	initial begin
		decoder      = new();
		arst_n       = 1'b0;
		item_valid   = 1'b0;
		item         = '0;
		calm         = 1'b0;
		drained_once = 1'b0;
		random_bytes = 0;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		directed_files();
		while (random_bytes < RANDOM_BYTES) random_file();
		calm = 1'b0;

		item_valid <= 1'b0;
		while (decoder.pixels_due.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
		if (decoder.mismatches == 0 && decoder.pixels_due.size() == 0 && drained_once) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("TEST FAILED");
		$finish;
	end

endmodule
